FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    `ASSERT_AT(label, clk, rst_n, !(cond))
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

FILE: rtl/ecs_pkg.sv
// ----------------------------------------------------------------------------
// Equity curve statistics package
// Payload types, unit request/response types and shared constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ecs_pkg;

    localparam int EqW      = 48;
    localparam int CntW     = 32;
    localparam int RetFrac  = 24;
    localparam int VarW     = 64 - RetFrac;
    localparam int DenW     = 48;
    localparam int StepW    = 7;

    typedef struct packed {
        logic signed [EqW-1:0] equity;
        logic                  final_sample;
    } in_t;

    typedef struct packed {
        logic [31:0]        sample_count;
        logic [31:0]        win_count;
        logic [31:0]        loss_count;
        logic [16:0]        win_fraction;
        logic signed [31:0] sharpe;
        logic [23:0]        worst_drawdown;
        logic               zero_peak_seen;
    } out_t;

    typedef struct packed {
        logic             start;
        logic [63:0]      num;
        logic [DenW-1:0]  den;
        logic [StepW-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quo;
        logic        ovf;
    } div_rsp_t;

    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] v;
    } sqrt_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
        return (&c) ? c : c + CntW'(1);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/equity_curve_statistics.sv
// ----------------------------------------------------------------------------
// Equity curve statistics
// Win/loss counts, win rate, Sharpe ratio and maximum drawdown of a curve.
// ----------------------------------------------------------------------------
// One sample is taken at a time; s_ready is high only while the block is
// idle. The first sample of a curve only sets the peak. For a later sample
// the relative return is found by a pass of the bit-serial divider and then
// squared by the serial multiplier, unless the previous value is zero; a
// drawdown below a positive peak then needs a further divide. The divides
// run one quotient bit per cycle through a single shared divider. The last
// sample of a curve then goes on to the win rate, mean, mean square,
// variance, square root and Sharpe divide before the result transaction
// is offered; the statistics then clear for the next curve. A waiting
// result does not stop the block from taking further samples.
`default_nettype none
`include "assert_macros.svh"

module equity_curve_statistics (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire ecs_pkg::in_t s_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output ecs_pkg::out_t     m_data
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_RET_WAIT, ST_SQ_WAIT, ST_DD, ST_DD_WAIT, ST_UPD,
        ST_WF_GO, ST_WF_WAIT, ST_MEAN_GO, ST_MEAN_WAIT, ST_MSQ_GO,
        ST_MSQ_WAIT, ST_MM_GO, ST_MM_WAIT, ST_ROOT_GO, ST_ROOT_WAIT,
        ST_SH_GO, ST_SH_WAIT, ST_EMIT
    } state_t;

    localparam int EqW  = ecs_pkg::EqW;
    localparam int CntW = ecs_pkg::CntW;
    localparam int VarW = ecs_pkg::VarW;
    localparam int Frac = ecs_pkg::RetFrac;

    state_t                       state_reg, state_next;
    logic signed [EqW-1:0]        cur_reg, cur_next;
    logic                         fin_reg, fin_next;
    logic [CntW-1:0]              samples_reg, samples_next;
    logic signed [EqW-1:0]        prev_reg, prev_next;
    logic signed [EqW-1:0]        peak_reg, peak_next;
    logic [CntW-1:0]              wins_reg, wins_next;
    logic [CntW-1:0]              losses_reg, losses_next;
    logic [CntW-1:0]              nret_reg, nret_next;
    logic signed [63:0]           sum_reg, sum_next;
    logic [63:0]                  sqs_reg, sqs_next;
    logic [23:0]                  dd_reg, dd_next;
    logic                         zpf_reg, zpf_next;
    logic                         neg_reg, neg_next;
    logic                         dnz_reg, dnz_next;
    logic [30:0]                  mag_reg, mag_next;
    logic [16:0]                  wf_reg, wf_next;
    logic [31:0]                  mean_reg, mean_next;
    logic [63:0]                  msq_reg, msq_next;
    logic [VarW-1:0]              var_reg, var_next;
    logic [31:0]                  sharpe_reg, sharpe_next;
    logic                         ok_reg, ok_next;
    logic                         m_valid_reg, m_valid_next;
    ecs_pkg::out_t                out_reg, out_next;
    ecs_pkg::div_req_t            div_req_reg, div_req_next;
    ecs_pkg::mul_req_t            mul_req_reg, mul_req_next;
    ecs_pkg::sqrt_req_t           sqrt_req_reg, sqrt_req_next;
    ecs_pkg::div_rsp_t            div_rsp;
    ecs_pkg::mul_rsp_t            mul_rsp;
    ecs_pkg::sqrt_rsp_t           sqrt_rsp;

    logic signed [EqW:0]          ret_diff;
    logic [EqW:0]                 abs_diff;
    logic [EqW-1:0]               abs_prev;
    logic signed [EqW:0]          dd_diff;
    logic [CntW:0]                decided;
    logic [63:0]                  abs_sum;
    logic signed [31:0]           ret_signed;
    logic signed [64:0]           sum_wide;
    logic [64:0]                  sqs_wide;
    logic [63:0]                  sq_term;
    logic [63:0]                  mm_term;
    logic [63:0]                  var_full;
    logic [23:0]                  dd_new;
    logic [31:0]                  sh_lim;
    logic [31:0]                  sh_mag;

    ecs_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req_reg), .rsp(div_rsp));
    ecs_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mul_req_reg), .rsp(mul_rsp));
    ecs_sqrt u_sqrt (.aclk(aclk), .aresetn(aresetn), .req(sqrt_req_reg), .rsp(sqrt_rsp));

    always_comb begin
        ret_diff   = {s_data.equity[EqW-1], s_data.equity} - {prev_reg[EqW-1], prev_reg};
        abs_diff   = ret_diff[EqW] ? (EqW+1)'(0) - ret_diff : ret_diff;
        abs_prev   = prev_reg[EqW-1] ? EqW'(0) - prev_reg : prev_reg;
        dd_diff    = {peak_reg[EqW-1], peak_reg} - {cur_reg[EqW-1], cur_reg};
        decided    = {1'b0, wins_reg} + {1'b0, losses_reg};
        abs_sum    = sum_reg[63] ? 64'd0 - sum_reg : sum_reg;
        ret_signed = neg_reg ? 32'sd0 - {1'b0, mag_reg} : {1'b0, mag_reg};
        sum_wide   = {sum_reg[63], sum_reg} + {{33{ret_signed[31]}}, ret_signed};
        sq_term    = {{Frac{1'b0}}, mul_rsp.prod[63:Frac]};
        sqs_wide   = {1'b0, sqs_reg} + {1'b0, sq_term};
        mm_term    = {{Frac{1'b0}}, mul_rsp.prod[63:Frac]};
        var_full   = (msq_reg > mm_term) ? msq_reg - mm_term : 64'd0;
        dd_new     = (div_rsp.ovf || div_rsp.quo[63:24] != '0) ? 24'hFF_FFFF
                                                              : div_rsp.quo[23:0];
        sh_lim     = sum_reg[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        sh_mag     = (div_rsp.ovf || div_rsp.quo[63:32] != '0 ||
                      div_rsp.quo[31:0] > sh_lim) ? sh_lim : div_rsp.quo[31:0];

        state_next    = state_reg;
        cur_next      = cur_reg;
        fin_next      = fin_reg;
        samples_next  = samples_reg;
        prev_next     = prev_reg;
        peak_next     = peak_reg;
        wins_next     = wins_reg;
        losses_next   = losses_reg;
        nret_next     = nret_reg;
        sum_next      = sum_reg;
        sqs_next      = sqs_reg;
        dd_next       = dd_reg;
        zpf_next      = zpf_reg;
        neg_next      = neg_reg;
        dnz_next      = dnz_reg;
        mag_next      = mag_reg;
        wf_next       = wf_reg;
        mean_next     = mean_reg;
        msq_next      = msq_reg;
        var_next      = var_reg;
        sharpe_next   = sharpe_reg;
        ok_next       = ok_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg & ~m_ready;
        div_req_next  = div_req_reg;
        mul_req_next  = mul_req_reg;
        sqrt_req_next = sqrt_req_reg;
        div_req_next.start  = 1'b0;
        mul_req_next.start  = 1'b0;
        sqrt_req_next.start = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cur_next = s_data.equity;
                    fin_next = s_data.final_sample;
                    neg_next = ret_diff[EqW] != prev_reg[EqW-1];
                    dnz_next = ret_diff != '0;
                    if (samples_reg == '0) begin
                        peak_next  = s_data.equity;
                        state_next = ST_UPD;
                    end else if (prev_reg != '0) begin
                        div_req_next.start = 1'b1;
                        div_req_next.num   = {abs_diff, {(63-EqW){1'b0}}};
                        div_req_next.den   = abs_prev;
                        div_req_next.steps = ecs_pkg::StepW'(EqW + 1 + Frac);
                        state_next         = ST_RET_WAIT;
                    end else begin
                        state_next = ST_DD;
                    end
                end
            end
            ST_RET_WAIT: begin
                if (div_rsp.done) begin
                    mag_next = (div_rsp.ovf || div_rsp.quo[63:31] != '0)
                               ? 31'h7FFF_FFFF : div_rsp.quo[30:0];
                    if (dnz_reg) begin
                        if (neg_reg) begin
                            losses_next = ecs_pkg::sat_inc(losses_reg);
                        end else begin
                            wins_next = ecs_pkg::sat_inc(wins_reg);
                        end
                    end
                    mul_req_next.start = 1'b1;
                    mul_req_next.a     = {1'b0, mag_next};
                    mul_req_next.b     = {1'b0, mag_next};
                    state_next         = ST_SQ_WAIT;
                end
            end
            ST_SQ_WAIT: begin
                if (mul_rsp.done) begin
                    nret_next = ecs_pkg::sat_inc(nret_reg);
                    // saturate the running sums rather than wrap
                    if (sum_wide[64] != sum_wide[63]) begin
                        sum_next = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                    end else begin
                        sum_next = sum_wide[63:0];
                    end
                    sqs_next   = sqs_wide[64] ? {64{1'b1}} : sqs_wide[63:0];
                    state_next = ST_DD;
                end
            end
            ST_DD: begin
                if (cur_reg > peak_reg) begin
                    peak_next  = cur_reg;
                    state_next = ST_UPD;
                end else if (peak_reg == '0) begin
                    zpf_next   = 1'b1;
                    state_next = ST_UPD;
                end else if (!peak_reg[EqW-1]) begin
                    div_req_next.start = 1'b1;
                    div_req_next.num   = {dd_diff[EqW-1:0], {(64-EqW){1'b0}}};
                    div_req_next.den   = peak_reg;
                    div_req_next.steps = ecs_pkg::StepW'(EqW + 16);
                    state_next         = ST_DD_WAIT;
                end else begin
                    state_next = ST_UPD;
                end
            end
            ST_DD_WAIT: begin
                if (div_rsp.done) begin
                    if (dd_new > dd_reg) begin
                        dd_next = dd_new;
                    end
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                prev_next    = cur_reg;
                samples_next = ecs_pkg::sat_inc(samples_reg);
                if (fin_reg) begin
                    ok_next     = samples_reg != '0;
                    wf_next     = '0;
                    sharpe_next = '0;
                    state_next  = (samples_reg != '0) ? ST_WF_GO : ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_WF_GO: begin
                if (decided == '0) begin
                    state_next = ST_MEAN_GO;
                end else begin
                    div_req_next.start = 1'b1;
                    div_req_next.num   = {wins_reg, {(64-CntW){1'b0}}};
                    div_req_next.den   = ecs_pkg::DenW'(decided);
                    div_req_next.steps = ecs_pkg::StepW'(CntW + 16);
                    state_next         = ST_WF_WAIT;
                end
            end
            ST_WF_WAIT: begin
                if (div_rsp.done) begin
                    wf_next    = div_rsp.quo[16:0];
                    state_next = ST_MEAN_GO;
                end
            end
            ST_MEAN_GO: begin
                if (nret_reg == '0) begin
                    state_next = ST_EMIT;
                end else begin
                    div_req_next.start = 1'b1;
                    div_req_next.num   = abs_sum;
                    div_req_next.den   = ecs_pkg::DenW'(nret_reg);
                    div_req_next.steps = ecs_pkg::StepW'(64);
                    state_next         = ST_MEAN_WAIT;
                end
            end
            ST_MEAN_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.ovf || div_rsp.quo[63:32] != '0 ||
                        (div_rsp.quo[31] && div_rsp.quo[30:0] != '0)) begin
                        mean_next = 32'h8000_0000;
                    end else begin
                        mean_next = div_rsp.quo[31:0];
                    end
                    state_next = ST_MSQ_GO;
                end
            end
            ST_MSQ_GO: begin
                div_req_next.start = 1'b1;
                div_req_next.num   = sqs_reg;
                div_req_next.den   = ecs_pkg::DenW'(nret_reg);
                div_req_next.steps = ecs_pkg::StepW'(64);
                state_next         = ST_MSQ_WAIT;
            end
            ST_MSQ_WAIT: begin
                if (div_rsp.done) begin
                    msq_next   = div_rsp.ovf ? {64{1'b1}} : div_rsp.quo;
                    state_next = ST_MM_GO;
                end
            end
            ST_MM_GO: begin
                mul_req_next.start = 1'b1;
                mul_req_next.a     = mean_reg;
                mul_req_next.b     = mean_reg;
                state_next         = ST_MM_WAIT;
            end
            ST_MM_WAIT: begin
                if (mul_rsp.done) begin
                    var_next   = (var_full[63:VarW] != '0) ? {VarW{1'b1}}
                                                           : var_full[VarW-1:0];
                    state_next = ST_ROOT_GO;
                end
            end
            ST_ROOT_GO: begin
                sqrt_req_next.start = 1'b1;
                sqrt_req_next.v     = {var_reg, {Frac{1'b0}}};
                state_next          = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT: begin
                if (sqrt_rsp.done) begin
                    state_next = (sqrt_rsp.root == '0 || mean_reg == '0) ? ST_EMIT
                                                                         : ST_SH_GO;
                end
            end
            ST_SH_GO: begin
                div_req_next.start = 1'b1;
                div_req_next.num   = {mean_reg, 32'd0};
                div_req_next.den   = ecs_pkg::DenW'(sqrt_rsp.root);
                div_req_next.steps = ecs_pkg::StepW'(32 + 16);
                state_next         = ST_SH_WAIT;
            end
            ST_SH_WAIT: begin
                if (div_rsp.done) begin
                    sharpe_next = sum_reg[63] ? 32'd0 - sh_mag : sh_mag;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold until the output stage is free, then clear for the next curve
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (ok_reg) begin
                        out_next.sample_count   = samples_reg;
                        out_next.win_count      = wins_reg;
                        out_next.loss_count     = losses_reg;
                        out_next.win_fraction   = wf_reg;
                        out_next.sharpe         = sharpe_reg;
                        out_next.worst_drawdown = dd_reg;
                        out_next.zero_peak_seen = zpf_reg;
                    end else begin
                        out_next = '0;
                    end
                    samples_next = '0;
                    prev_next    = '0;
                    peak_next    = '0;
                    wins_next    = '0;
                    losses_next  = '0;
                    nret_next    = '0;
                    sum_next     = '0;
                    sqs_next     = '0;
                    dd_next      = '0;
                    zpf_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            samples_reg        <= '0;
            prev_reg           <= '0;
            peak_reg           <= '0;
            wins_reg           <= '0;
            losses_reg         <= '0;
            nret_reg           <= '0;
            sum_reg            <= '0;
            sqs_reg            <= '0;
            dd_reg             <= '0;
            zpf_reg            <= 1'b0;
            m_valid_reg        <= 1'b0;
            div_req_reg.start  <= 1'b0;
            mul_req_reg.start  <= 1'b0;
            sqrt_req_reg.start <= 1'b0;
        end else begin
            state_reg    <= state_next;
            samples_reg  <= samples_next;
            prev_reg     <= prev_next;
            peak_reg     <= peak_next;
            wins_reg     <= wins_next;
            losses_reg   <= losses_next;
            nret_reg     <= nret_next;
            sum_reg      <= sum_next;
            sqs_reg      <= sqs_next;
            dd_reg       <= dd_next;
            zpf_reg      <= zpf_next;
            m_valid_reg  <= m_valid_next;
            div_req_reg  <= div_req_next;
            mul_req_reg  <= mul_req_next;
            sqrt_req_reg <= sqrt_req_next;
        end
        cur_reg    <= cur_next;
        fin_reg    <= fin_next;
        neg_reg    <= neg_next;
        dnz_reg    <= dnz_next;
        mag_reg    <= mag_next;
        wf_reg     <= wf_next;
        mean_reg   <= mean_next;
        msq_reg    <= msq_next;
        var_reg    <= var_next;
        sharpe_reg <= sharpe_next;
        ok_reg     <= ok_next;
        out_reg    <= out_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `ASSERT_AT(a_ready_units_idle, aclk, aresetn, s_ready |-> (!div_rsp.busy && !mul_rsp.busy && !sqrt_rsp.busy))
    `ASSERT_AT(a_div_start_free, aclk, aresetn, div_req_reg.start |-> !div_rsp.busy)
    `ASSERT_AT(a_short_curve_zero, aclk, aresetn, (m_valid && m_data.sample_count == 32'd0) |-> (m_data.win_count == 32'd0 && m_data.sharpe == 32'sd0 && !m_data.zero_peak_seen))
    `ASSERT_NEVER(a_win_fraction_range, aclk, aresetn, m_valid && m_data.win_fraction > 17'd65536)
    `ASSERT_AT(a_cleared_after_emit, aclk, aresetn, $rose(m_valid) |-> (samples_reg == '0 && nret_reg == '0))

endmodule

`default_nettype wire

FILE: rtl/ecs_div.sv
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring long division, one quotient bit per cycle, sticky overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module ecs_div (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire ecs_pkg::div_req_t req,
    output ecs_pkg::div_rsp_t      rsp
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [63:0]                 num_reg, num_next;
    logic [63:0]                 quo_reg, quo_next;
    logic [ecs_pkg::DenW-1:0]    den_reg, den_next;
    logic [ecs_pkg::DenW-1:0]    rem_reg, rem_next;
    logic                        ovf_reg, ovf_next;
    logic [ecs_pkg::StepW-1:0]   cnt_reg, cnt_next;
    logic [ecs_pkg::DenW:0]      trial;
    logic [ecs_pkg::DenW:0]      sub;
    logic                        ge;

    always_comb begin
        trial = {rem_reg, num_reg[63]};
        ge    = trial >= {1'b0, den_reg};
        sub   = trial - {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        num_next  = num_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;

        if (req.start) begin
            busy_next = 1'b1;
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            quo_next  = '0;
            ovf_next  = 1'b0;
            cnt_next  = req.steps;
        end else if (busy_reg) begin
            rem_next = ge ? sub[ecs_pkg::DenW-1:0] : trial[ecs_pkg::DenW-1:0];
            quo_next = {quo_reg[62:0], ge};
            // a bit leaving the top means the quotient no longer fits
            ovf_next = ovf_reg | quo_reg[63];
            num_next = {num_reg[62:0], 1'b0};
            cnt_next = cnt_reg - ecs_pkg::StepW'(1);
            if (cnt_reg == ecs_pkg::StepW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        ovf_reg <= ovf_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.ovf  = ovf_reg;

endmodule

`default_nettype wire

FILE: rtl/ecs_mul.sv
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Unsigned 32 x 32 shift-and-add, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ecs_mul (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire ecs_pkg::mul_req_t req,
    output ecs_pkg::mul_rsp_t      rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] prod_reg, prod_next;
    logic [31:0] mcand_reg, mcand_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] addend;
    logic [32:0] psum;

    always_comb begin
        addend = prod_reg[0] ? mcand_reg : 32'd0;
        psum   = {1'b0, prod_reg[63:32]} + {1'b0, addend};

        busy_next  = busy_reg;
        done_next  = 1'b0;
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        cnt_next   = cnt_reg;

        if (req.start) begin
            busy_next  = 1'b1;
            prod_next  = {32'd0, req.a};
            mcand_next = req.b;
            cnt_next   = 6'd32;
        end else if (busy_reg) begin
            prod_next = {psum, prod_reg[31:1]};
            cnt_next  = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
        cnt_reg   <= cnt_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.prod = prod_reg;

endmodule

`default_nettype wire

FILE: rtl/ecs_sqrt.sv
// ----------------------------------------------------------------------------
// Digit-serial square root
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ecs_sqrt (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ecs_pkg::sqrt_req_t req,
    output ecs_pkg::sqrt_rsp_t      rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] v_reg, v_next;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [35:0] t;
    logic [35:0] trial;
    logic [35:0] sub;
    logic        ge;

    always_comb begin
        t     = {rem_reg, v_reg[63:62]};
        trial = {2'b00, root_reg, 2'b01};
        ge    = t >= trial;
        sub   = t - trial;

        busy_next = busy_reg;
        done_next = 1'b0;
        v_next    = v_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;

        if (req.start) begin
            busy_next = 1'b1;
            v_next    = req.v;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 6'd32;
        end else if (busy_reg) begin
            rem_next  = ge ? sub[33:0] : t[33:0];
            root_next = {root_reg[30:0], ge};
            v_next    = {v_reg[61:0], 2'b00};
            cnt_next  = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        v_reg    <= v_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

`default_nettype wire
